// ===== design/blank_row_column_trim_defines.svh =====
// assertion macros for the blank row and column trim block
// depends on clock and reset being in scope where a macro is used
`ifndef BLANK_ROW_COLUMN_TRIM_DEFINES_SVH
`define BLANK_ROW_COLUMN_TRIM_DEFINES_SVH

// same-cycle implication
`define BRCT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BRCT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/brct_pkg.sv =====
// types and codes for the blank row and column trim block
// no dependencies
`timescale 1ns / 1ps

package brct_pkg;

   localparam logic [7:0] BLANK_CODE = 8'h2E;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_FETCH = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;
   localparam logic [1:0] ACT_NOP   = 2'd3;

   localparam logic [1:0] ST_CELL       = 2'd0;
   localparam logic [1:0] ST_DONE       = 2'd1;
   localparam logic [1:0] ST_NOT_LOADED = 2'd2;

   localparam logic [0:0] CSR_GRID_ROWS = 1'b0;
   localparam logic [0:0] CSR_GRID_COLS = 1'b1;

   typedef enum logic [1:0] {
      IDLE,
      ROW_SCAN,
      COL_SCAN,
      END_SCAN
   } state_type;

endpackage

// ===== design/blank_row_column_trim.sv =====
// blank row and column trim: loads a character grid, returns the cropped cells
// depends on brct_pkg and blank_row_column_trim_defines.svh
`timescale 1ns / 1ps
// Usage
//   csr_*  : write grid_rows (index 0) and grid_cols (index 1) while idle.
//            0 counts as 1, values above MAX_ROWS / MAX_COLS are clamped.
//   req_*  : one request per accepted edge. action 0 loads the next cell
//            in row-major order, 1 fetches the next kept cell, 2 clears the
//            flags and positions for a new grid, 3 does nothing.
//   rsp_*  : one response per fetch: cell_out, row_end and status
//            (0 cell, 1 no more kept cells, 2 grid not fully loaded).
// Timing
//   Load, clear and no-op requests do not start a walk; the block stays idle for the next request.
//   A fetch on a partly loaded grid answers on the next cycle. Otherwise
//   the walker checks one flag or bound per cycle: each row it visits,
//   each column up to the kept cell, each column after it up to the next
//   inked one, and each row or column end it reaches. The response is
//   registered when the walk ends. All requests stall during a walk,
//   and a fetch also while a response is pending; loads and clears are
//   still taken while a response is stalled.
// Reset
//   Registers return to 1, flags and positions to zero. Grid storage is
//   not cleared; no clearing pass is needed.
`include "blank_row_column_trim_defines.svh"

module blank_row_column_trim #(
   parameter int MAX_ROWS = 128,
   parameter int MAX_COLS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_cell_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_cell_out,
   output logic        rsp_row_end,
   output logic [1:0]  rsp_status
);

   localparam int RCW   = $clog2(MAX_ROWS + 1);
   localparam int CCW   = $clog2(MAX_COLS + 1);
   localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW    = (RCW > 8) ? RCW : 8;
   localparam int CW    = (CCW > 8) ? CCW : 8;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0]          grid_rows_ff, grid_rows_in;
   logic [7:0]          grid_cols_ff, grid_cols_in;
   logic [RW-1:0]       rows_raw;
   logic [CW-1:0]       cols_raw;
   logic [RCW-1:0]      rows_eff;
   logic [CCW-1:0]      cols_eff;

   brct_pkg::state_type state_ff, state_in;
   logic [RCW-1:0]      load_row_ff, load_row_in;
   logic [CIW-1:0]      load_col_ff, load_col_in;
   logic [RCW-1:0]      out_row_ff, out_row_in;
   logic [CCW-1:0]      out_col_ff, out_col_in;
   logic [CCW-1:0]      scan_col_ff, scan_col_in;
   logic [MAX_ROWS-1:0] row_flag_ff, row_flag_in;
   logic [MAX_COLS-1:0] col_flag_ff, col_flag_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_cell_ff, rsp_cell_in;
   logic                rsp_row_end_ff, rsp_row_end_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic [7:0]          grid_mem [DEPTH];
   logic [7:0]          mem_rd_ff;
   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr, rd_addr;

   logic                req_take;
   logic [RCW-1:0]      ld_row_a, ld_row_b;
   logic [CCW-1:0]      ld_col_a, ld_col_b;
   logic                ld_ok;
   logic                row_hit, col_hit, end_hit;

   // clamped counts
   assign rows_raw = RW'(grid_rows_ff);
   assign cols_raw = CW'(grid_cols_ff);
   assign rows_eff = (rows_raw == '0) ? RCW'(1) :
                     (rows_raw > RW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_raw);
   assign cols_eff = (cols_raw == '0) ? CCW'(1) :
                     (cols_raw > CW'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(cols_raw);

   assign req_stall = (state_ff != brct_pkg::IDLE) ||
                      (rsp_valid_ff && (req_action == brct_pkg::ACT_FETCH));
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_out = rsp_cell_ff;
   assign rsp_row_end  = rsp_row_end_ff;
   assign rsp_status   = rsp_status_ff;

   assign row_hit = row_flag_ff[out_row_ff[RIW-1:0]];
   assign col_hit = col_flag_ff[out_col_ff[CIW-1:0]];
   assign end_hit = col_flag_ff[scan_col_ff[CIW-1:0]];

   // load position: wrap a stale column first, then step past the written cell
   always_comb begin
      ld_row_a = load_row_ff;
      ld_col_a = CCW'(load_col_ff);
      if (ld_col_a >= cols_eff) begin
         ld_col_a = '0;
         if (ld_row_a < rows_eff) begin
            ld_row_a = ld_row_a + RCW'(1);
         end
      end
      ld_ok    = ld_row_a < rows_eff;
      ld_row_b = ld_row_a;
      ld_col_b = ld_col_a + CCW'(1);
      if (ld_col_b >= cols_eff) begin
         ld_col_b = '0;
         ld_row_b = ld_row_a + RCW'(1);
      end
   end

   assign wr_addr = AW'(ld_row_a[RIW-1:0]) * AW'(MAX_COLS) + AW'(ld_col_a[CIW-1:0]);
   assign rd_addr = AW'(out_row_ff[RIW-1:0]) * AW'(MAX_COLS) + AW'(out_col_ff[CIW-1:0]);

   // config registers
   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      if (csr_write_en) begin
         if (csr_index == brct_pkg::CSR_GRID_ROWS) begin
            grid_rows_in = csr_write_data;
         end else begin
            grid_cols_in = csr_write_data;
         end
      end
   end

   // sequencer: next state and datapath
   always_comb begin
      state_in       = state_ff;
      load_row_in    = load_row_ff;
      load_col_in    = load_col_ff;
      out_row_in     = out_row_ff;
      out_col_in     = out_col_ff;
      scan_col_in    = scan_col_ff;
      row_flag_in    = row_flag_ff;
      col_flag_in    = col_flag_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_cell_in    = rsp_cell_ff;
      rsp_row_end_in = rsp_row_end_ff;
      rsp_status_in  = rsp_status_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;

      unique case (state_ff)
         brct_pkg::IDLE: begin
            if (req_take) begin
               unique case (req_action)
                  brct_pkg::ACT_LOAD: begin
                     if (ld_ok) begin
                        wr_en       = 1'b1;
                        load_row_in = ld_row_b;
                        load_col_in = CIW'(ld_col_b);
                        if (req_cell_in != brct_pkg::BLANK_CODE) begin
                           row_flag_in[ld_row_a[RIW-1:0]] = 1'b1;
                           col_flag_in[ld_col_a[CIW-1:0]] = 1'b1;
                        end
                     end else begin
                        load_row_in = ld_row_a;
                        load_col_in = CIW'(ld_col_a);
                     end
                  end
                  brct_pkg::ACT_FETCH: begin
                     if (load_row_ff < rows_eff) begin
                        rsp_valid_in   = 1'b1;
                        rsp_cell_in    = '0;
                        rsp_row_end_in = 1'b0;
                        rsp_status_in  = brct_pkg::ST_NOT_LOADED;
                     end else begin
                        state_in = brct_pkg::ROW_SCAN;
                     end
                  end
                  brct_pkg::ACT_CLEAR: begin
                     row_flag_in = '0;
                     col_flag_in = '0;
                     load_row_in = '0;
                     load_col_in = '0;
                     out_row_in  = '0;
                     out_col_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         brct_pkg::ROW_SCAN: begin
            if (out_row_ff >= rows_eff) begin
               state_in       = brct_pkg::IDLE;
               rsp_valid_in   = 1'b1;
               rsp_cell_in    = '0;
               rsp_row_end_in = 1'b0;
               rsp_status_in  = brct_pkg::ST_DONE;
            end else if (row_hit) begin
               state_in = brct_pkg::COL_SCAN;
            end else begin
               out_row_in = out_row_ff + RCW'(1);
               out_col_in = '0;
            end
         end
         brct_pkg::COL_SCAN: begin
            if (out_col_ff >= cols_eff) begin
               state_in   = brct_pkg::ROW_SCAN;
               out_row_in = out_row_ff + RCW'(1);
               out_col_in = '0;
            end else if (col_hit) begin
               state_in    = brct_pkg::END_SCAN;
               rd_en       = 1'b1;
               out_col_in  = out_col_ff + CCW'(1);
               scan_col_in = out_col_ff + CCW'(1);
            end else begin
               out_col_in = out_col_ff + CCW'(1);
            end
         end
         brct_pkg::END_SCAN: begin
            if ((scan_col_ff >= cols_eff) || end_hit) begin
               state_in       = brct_pkg::IDLE;
               rsp_valid_in   = 1'b1;
               rsp_cell_in    = mem_rd_ff;
               rsp_row_end_in = scan_col_ff >= cols_eff;
               rsp_status_in  = brct_pkg::ST_CELL;
            end else begin
               scan_col_in = scan_col_ff + CCW'(1);
            end
         end
         default: begin
            state_in = brct_pkg::IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brct_pkg::IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= 8'd1;
         grid_cols_ff <= 8'd1;
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         scan_col_ff  <= '0;
         row_flag_ff  <= '0;
         col_flag_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         scan_col_ff  <= scan_col_in;
         row_flag_ff  <= row_flag_in;
         col_flag_ff  <= col_flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cell_ff    <= rsp_cell_in;
      rsp_row_end_ff <= rsp_row_end_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // grid storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= req_cell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_rd_ff <= grid_mem[rd_addr];
      end
   end

   `BRCT_ASSERT_IMP(a_col_scan_on_inked_row, state_ff == brct_pkg::COL_SCAN,
      (out_row_ff < rows_eff) && row_hit, "column walk on a row without ink")
   `BRCT_ASSERT_IMP(a_end_scan_past_hit, state_ff == brct_pkg::END_SCAN,
      (out_col_ff != '0) && (scan_col_ff >= out_col_ff), "row end walk behind the kept cell")
   `BRCT_ASSERT_IMP(a_fetch_slot_free, req_take && (req_action == brct_pkg::ACT_FETCH),
      !rsp_valid_ff, "fetch taken while a response is pending")
   `BRCT_ASSERT_NXT(a_walk_ends_in_cell,
      (state_ff == brct_pkg::END_SCAN) && (state_in == brct_pkg::IDLE),
      rsp_valid_ff && (rsp_status_ff == brct_pkg::ST_CELL), "finished walk gave no cell response")

endmodule

// ===== tb/sv/tb_blank_row_column_trim.sv =====
// testbench for blank_row_column_trim: grids of random size and content are loaded,
// the cropped cells fetched and each response checked against a scoreboard model
// depends on brct_pkg and the blank_row_column_trim rtl
`timescale 1ns / 1ps

module tb_blank_row_column_trim;

   localparam int GRID_SIDE = 128;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REQUEST_TARGET = 2000;

   typedef struct {
      logic [7:0] cell_code;
      logic       row_end;
      logic [1:0] status;
   } crop_result_type;

   class crop_scoreboard_type;
      logic [7:0]  cell_grid [GRID_SIDE * GRID_SIDE];
      bit          row_ink [GRID_SIDE];
      bit          col_ink [GRID_SIDE];
      logic [7:0]  rows_reg;
      logic [7:0]  cols_reg;
      int unsigned load_row;
      int unsigned load_col;
      int unsigned walk_row;
      int unsigned walk_col;
      logic [1:0]  last_status;
      crop_result_type expected_crops [$];
      int          error_count;

      function new();
         rows_reg = 8'd1;
         cols_reg = 8'd1;
         last_status = brct_pkg::ST_DONE;
         error_count = 0;
         clear_marks();
      endfunction

      function int unsigned count_of(logic [7:0] value);
         if (value == 8'd0) return 1;
         if (value > GRID_SIDE) return GRID_SIDE;
         return value;
      endfunction

      function void clear_marks();
         foreach (row_ink[i]) row_ink[i] = 1'b0;
         foreach (col_ink[i]) col_ink[i] = 1'b0;
         load_row = 0;
         load_col = 0;
         walk_row = 0;
         walk_col = 0;
      endfunction

      function void note_config(logic [0:0] index, logic [7:0] value);
         if (index == brct_pkg::CSR_GRID_ROWS) rows_reg = value;
         else cols_reg = value;
      endfunction

      function int unsigned next_marked_col(int unsigned col, int unsigned cols);
         int unsigned c;
         c = col;
         while (c < cols && !col_ink[c]) c++;
         return c;
      endfunction

      function int loads_left();
         int unsigned rows, cols, r, c;
         rows = count_of(rows_reg);
         cols = count_of(cols_reg);
         r = load_row;
         c = load_col;
         if (c >= cols) begin
            c = 0;
            if (r < rows) r++;
         end
         if (r >= rows) return 0;
         return (rows - r) * cols - c;
      endfunction

      function crop_result_type predict_fetch(int unsigned rows, int unsigned cols);
         crop_result_type r;
         int unsigned c;
         r.cell_code = 8'h00;
         r.row_end = 1'b0;
         r.status = brct_pkg::ST_NOT_LOADED;
         if (load_row < rows) return r;
         while (walk_row < rows) begin
            if (row_ink[walk_row]) begin
               c = next_marked_col(walk_col, cols);
               if (c < cols) begin
                  r.cell_code = cell_grid[walk_row * GRID_SIDE + c];
                  r.row_end = (next_marked_col(c + 1, cols) >= cols);
                  r.status = brct_pkg::ST_CELL;
                  walk_col = c + 1;
                  return r;
               end
            end
            walk_row++;
            walk_col = 0;
         end
         r.status = brct_pkg::ST_DONE;
         return r;
      endfunction

      function void note_request(logic [1:0] action, logic [7:0] cell_code);
         int unsigned rows, cols;
         crop_result_type r;
         rows = count_of(rows_reg);
         cols = count_of(cols_reg);
         case (action)
            brct_pkg::ACT_CLEAR: clear_marks();
            brct_pkg::ACT_LOAD: begin
               if (load_col >= cols) begin
                  load_col = 0;
                  if (load_row < rows) load_row++;
               end
               if (load_row < rows) begin
                  cell_grid[load_row * GRID_SIDE + load_col] = cell_code;
                  if (cell_code != brct_pkg::BLANK_CODE) begin
                     row_ink[load_row] = 1'b1;
                     col_ink[load_col] = 1'b1;
                  end
                  load_col++;
                  if (load_col >= cols) begin
                     load_col = 0;
                     load_row++;
                  end
               end
            end
            brct_pkg::ACT_FETCH: begin
               r = predict_fetch(rows, cols);
               last_status = r.status;
               expected_crops = {expected_crops, r};
            end
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_crops.size();
      endfunction

      task report_mismatch(string msg);
         error_count++;
         $display("%0t ns mismatch: %s", $realtime, msg);
      endtask

      task check_response(logic [7:0] cell_code, logic row_end, logic [1:0] status);
         crop_result_type want;
         if (expected_crops.size() == 0) begin
            report_mismatch("response with no fetch waiting");
            return;
         end
         want = expected_crops.pop_front();
         if (cell_code !== want.cell_code)
            report_mismatch($sformatf("cell_out %h, want %h", cell_code, want.cell_code));
         if (row_end !== want.row_end)
            report_mismatch($sformatf("row_end %b, want %b", row_end, want.row_end));
         if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [0:0]  csr_index = brct_pkg::CSR_GRID_ROWS;
   logic [7:0]  csr_write_data = 8'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = brct_pkg::ACT_NOP;
   logic [7:0]  req_cell_in = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_cell_out;
   logic        rsp_row_end;
   logic [1:0]  rsp_status;

   crop_scoreboard_type sb;
   bit steady = 1'b0;
   int requests_sent = 0;
   int phase_count = 0;
   int quiet_cycles = 0;
   int hold_cycles = 0;
   int stall_run = 0;

   blank_row_column_trim dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_cell_in    (req_cell_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_out   (rsp_cell_out),
      .rsp_row_end    (rsp_row_end),
      .rsp_status     (rsp_status)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 8'($urandom_range(1, 6));
      if (roll < 85) return 8'($urandom_range(7, 24));
      if (roll < 93) return 8'($urandom_range(25, 128));
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd128;
         2: return 8'd255;
         default: return 8'($urandom_range(129, 254));
      endcase
   endfunction

   // response side stall pattern
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (rsp_stall || steady) begin
         rsp_stall <= 1'b0;
         hold_cycles <= $urandom_range(0, 8);
      end else begin
         stall_run = pick_gap();
         rsp_stall <= (stall_run != 0);
         hold_cycles <= stall_run;
      end
   end

   // response check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_cell_out, rsp_row_end, rsp_status);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || csr_write_en)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_blank_row_column_trim: done, errors");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [1:0] act, input logic [7:0] cell_code);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_cell_in <= cell_code;
      do @(posedge clock); while (req_stall);
      sb.note_request(act, cell_code);
      if (act != brct_pkg::ACT_NOP) requests_sent++;
   endtask

   task automatic write_registers(input logic [7:0] rows_val, input logic [7:0] cols_val);
      csr_write_en <= 1'b1;
      csr_index <= brct_pkg::CSR_GRID_ROWS;
      csr_write_data <= rows_val;
      @(posedge clock);
      sb.note_config(brct_pkg::CSR_GRID_ROWS, rows_val);
      csr_index <= brct_pkg::CSR_GRID_COLS;
      csr_write_data <= cols_val;
      @(posedge clock);
      sb.note_config(brct_pkg::CSR_GRID_COLS, cols_val);
      csr_write_en <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_phase(input bit mid_grid);
      logic [7:0] rows_val, cols_val, cell_code;
      int blank_pct, roll, abandon_after, fetched;
      wait_idle();
      steady = ($urandom_range(0, 4) == 0);
      rows_val = pick_count();
      // mid-grid changes never widen the columns, so no unloaded cell is ever read
      if (mid_grid) cols_val = 8'($urandom_range(0, sb.count_of(sb.cols_reg)));
      else cols_val = pick_count();
      if (sb.count_of(rows_val) * sb.count_of(cols_val) > 512)
         rows_val = 8'($urandom_range(0, 3));
      write_registers(rows_val, cols_val);
      if (!mid_grid) send_request(brct_pkg::ACT_CLEAR, 8'($urandom));
      case ($urandom_range(0, 4))
         0: blank_pct = 0;
         1: blank_pct = 40;
         2: blank_pct = 70;
         3: blank_pct = 90;
         default: blank_pct = 100;
      endcase
      while (sb.loads_left() > 0) begin
         roll = $urandom_range(0, 999);
         if (roll < 20) send_request(brct_pkg::ACT_NOP, 8'($urandom));
         else if (roll < 50) send_request(brct_pkg::ACT_FETCH, 8'($urandom));
         else if (roll == 50) send_request(brct_pkg::ACT_CLEAR, 8'($urandom));
         cell_code = ($urandom_range(0, 99) < blank_pct) ? brct_pkg::BLANK_CODE :
                     8'($urandom_range(0, 255));
         send_request(brct_pkg::ACT_LOAD, cell_code);
      end
      repeat ($urandom_range(0, 2)) send_request(brct_pkg::ACT_LOAD, 8'($urandom));
      abandon_after = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : -1;
      fetched = 0;
      do begin
         roll = $urandom_range(0, 99);
         if (roll < 3) send_request(brct_pkg::ACT_NOP, 8'($urandom));
         else if (roll < 6) send_request(brct_pkg::ACT_LOAD, 8'($urandom));
         send_request(brct_pkg::ACT_FETCH, 8'($urandom));
         fetched++;
         if (fetched == abandon_after) begin
            send_request(brct_pkg::ACT_CLEAR, 8'($urandom));
            return;
         end
      end while (sb.last_status == brct_pkg::ST_CELL);
      repeat ($urandom_range(0, 2)) send_request(brct_pkg::ACT_FETCH, 8'($urandom));
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // two by three grid with a blank row and a blank middle column
      write_registers(8'd2, 8'd3);
      send_request(brct_pkg::ACT_CLEAR, 8'hFF);
      send_request(brct_pkg::ACT_LOAD, 8'h00);
      send_request(brct_pkg::ACT_FETCH, 8'h00);
      send_request(brct_pkg::ACT_LOAD, brct_pkg::BLANK_CODE);
      send_request(brct_pkg::ACT_LOAD, 8'hFF);
      send_request(brct_pkg::ACT_NOP, 8'hA5);
      repeat (3) send_request(brct_pkg::ACT_LOAD, brct_pkg::BLANK_CODE);
      send_request(brct_pkg::ACT_LOAD, 8'h5A);
      repeat (4) send_request(brct_pkg::ACT_FETCH, 8'hFF);
      send_request(brct_pkg::ACT_CLEAR, 8'h00);
      send_request(brct_pkg::ACT_FETCH, 8'h00);

      while (requests_sent < REQUEST_TARGET) begin
         run_phase(phase_count > 0 && $urandom_range(0, 5) == 0);
         phase_count++;
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("tb_blank_row_column_trim: done, clean");
      end else begin
         $display("tb_blank_row_column_trim: done, errors");
      end
      $finish;
   end

endmodule

// ===== blank_row_column_trim.f =====
+incdir+design
design/brct_pkg.sv
design/blank_row_column_trim.sv
tb/sv/tb_blank_row_column_trim.sv
